// ===== rtl/core/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared widths, threshold table and result type of the latency histogram.
// ----------------------------------------------------------------------------
package lsh_pkg;

	localparam int LAT_W       = 32;
	localparam int CNT_W       = 32;
	localparam int SUM_W       = 64;
	localparam int HIT_W       = 4;
	localparam int NUM_THRESH  = 9;
	localparam int BUCKETS_DEF = 9;

	localparam logic [HIT_W-1:0] NO_BUCKET = 4'd9;
	localparam logic [LAT_W:0]   OPEN_TOP  = {1'b1, {LAT_W{1'b0}}};

	typedef struct packed {
		logic [CNT_W-1:0] sample_count;
		logic [SUM_W-1:0] latency_sum;
		logic [LAT_W-1:0] latency_min;
		logic [LAT_W-1:0] latency_max;
		logic [HIT_W-1:0] bucket_hit;
		logic [CNT_W-1:0] bucket_count;
	} result_t;

	// bucket lower thresholds in microseconds, above the 32-bit range past the table
	function automatic logic [LAT_W:0] thresh_lookup(input int idx);
		logic [LAT_W:0] t;
		case (idx)
			0:       t = 33'd20000;
			1:       t = 33'd40000;
			2:       t = 33'd60000;
			3:       t = 33'd80000;
			4:       t = 33'd100000;
			5:       t = 33'd500000;
			6:       t = 33'd1000000;
			7:       t = 33'd2000000;
			8:       t = 33'd10000000;
			default: t = OPEN_TOP;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/lsh_bucket_sel.sv =====
// ----------------------------------------------------------------------------
// lsh_bucket_sel
// Finds the bucket whose thresholds strictly enclose a latency sample.
// ----------------------------------------------------------------------------
module lsh_bucket_sel import lsh_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  logic [LAT_W-1:0]   latency_us,
	output logic [BUCKETS-1:0] hit_vec,
	output logic [HIT_W-1:0]   hit_idx
);

	logic [LAT_W:0] sample;

	assign sample = {1'b0, latency_us};

	always_comb begin
		hit_vec = '0;
		hit_idx = NO_BUCKET;
		for (int i = 0; i < BUCKETS; i++) begin
			logic [LAT_W:0] lo;
			logic [LAT_W:0] hi;
			lo = thresh_lookup(i);
			hi = (i + 1 >= BUCKETS) ? OPEN_TOP : thresh_lookup(i + 1);
			if (sample > lo && sample < hi) begin
				hit_vec[i] = 1'b1;
				hit_idx    = HIT_W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/lsh_stats.sv =====
// ----------------------------------------------------------------------------
// lsh_stats
// Statistics registers and their combinational update for one sample.
// ----------------------------------------------------------------------------
module lsh_stats import lsh_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic [LAT_W-1:0] latency_us,
	input  logic             restart,
	output result_t          res
);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [LAT_W-1:0] min_q;
	logic [LAT_W-1:0] max_q;
	logic [CNT_W-1:0] bucket_q [BUCKETS];

	logic [CNT_W-1:0] count_base;
	logic [SUM_W-1:0] sum_base;
	logic [LAT_W-1:0] min_base;
	logic [LAT_W-1:0] max_base;
	logic [CNT_W-1:0] bucket_nxt [BUCKETS];
	logic [BUCKETS-1:0] hit_vec;
	logic [HIT_W-1:0]   hit_idx;
	logic [CNT_W-1:0]   hit_count;

	lsh_bucket_sel #(
		.BUCKETS(BUCKETS)
	) u_bucket_sel (
		.latency_us(latency_us),
		.hit_vec   (hit_vec),
		.hit_idx   (hit_idx)
	);

	// restart clears the statistics before the sample is added
	assign count_base = restart ? '0 : count_q;
	assign sum_base   = restart ? '0 : sum_q;
	assign min_base   = restart ? '1 : min_q;
	assign max_base   = restart ? '0 : max_q;

	always_comb begin
		hit_count = '0;
		for (int i = 0; i < BUCKETS; i++) begin
			bucket_nxt[i] = (restart ? '0 : bucket_q[i]) + CNT_W'(hit_vec[i]);
			if (hit_vec[i]) begin
				hit_count = bucket_nxt[i];
			end
		end
	end

	assign res.sample_count = count_base + CNT_W'(1);
	assign res.latency_sum  = sum_base + SUM_W'(latency_us);
	assign res.latency_min  = (latency_us < min_base) ? latency_us : min_base;
	assign res.latency_max  = (latency_us > max_base) ? latency_us : max_base;
	assign res.bucket_hit   = hit_idx;
	assign res.bucket_count = hit_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			for (int i = 0; i < BUCKETS; i++) begin
				bucket_q[i] <= '0;
			end
		end else if (upd) begin
			count_q <= res.sample_count;
			sum_q   <= res.latency_sum;
			min_q   <= res.latency_min;
			max_q   <= res.latency_max;
			for (int i = 0; i < BUCKETS; i++) begin
				bucket_q[i] <= bucket_nxt[i];
			end
		end
	end

endmodule

// ===== rtl/core/latency_stats_histogram.sv =====
// ----------------------------------------------------------------------------
// latency_stats_histogram
// Latency statistics (count, sum, min, max) with a fixed-threshold histogram.
// ----------------------------------------------------------------------------
// The input channel carries one latency sample in microseconds and a restart
// flag; a transfer happens when in_valid is high and in_stall is low. Restart
// clears every statistic before the sample is added.
// The output channel carries the statistics after each sample, the bucket hit
// (9 when none) and that bucket's new count; a transfer happens when out_valid
// is high and out_stall is low.
// A sample is registered in the input register at its input transfer, and its
// result is written to the output register once that register is free, which
// raises out_valid. Throughput is one sample per clock while the receiver does
// not stall; the update is a single pass of compares and adds between the
// input and output registers.
// Reset clears count, sum, max and all bucket counters, sets min to all ones
// and empties both registers. When the receiver stalls, the held result stays
// put, one more sample can still enter the input register, and in_stall rises
// only while both registers are full.
// ----------------------------------------------------------------------------
module latency_stats_histogram import lsh_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [LAT_W-1:0] latency_us,
	input  logic             restart,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CNT_W-1:0] sample_count,
	output logic [SUM_W-1:0] latency_sum,
	output logic [LAT_W-1:0] latency_min,
	output logic [LAT_W-1:0] latency_max,
	output logic [HIT_W-1:0] bucket_hit,
	output logic [CNT_W-1:0] bucket_count
);

	logic             valid_s1;
	logic [LAT_W-1:0] latency_s1;
	logic             restart_s1;
	logic             out_valid_q;
	result_t          res;
	result_t          out_q;
	logic             out_free;
	logic             move_s1;
	logic             in_xfer;

	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			latency_s1 <= latency_us;
			restart_s1 <= restart;
		end
	end

	lsh_stats #(
		.BUCKETS(BUCKETS)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (move_s1),
		.latency_us(latency_s1),
		.restart   (restart_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= move_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_count = out_q.sample_count;
	assign latency_sum  = out_q.latency_sum;
	assign latency_min  = out_q.latency_min;
	assign latency_max  = out_q.latency_max;
	assign bucket_hit   = out_q.bucket_hit;
	assign bucket_count = out_q.bucket_count;

endmodule
